@@ src/rc5rx_pkg.sv @@
package rc5rx_pkg;

    localparam int INTERVAL_W = 16;
    localparam int CMD_W      = 6;
    localparam int ADDR_W     = 5;
    localparam int WORD_W     = CMD_W + ADDR_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [3:0] LAST_SAMPLE = 4'd13;

    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 16'd1778;
    localparam logic [CMD_W-1:0]      RST_CODE_A   = 6'd0;
    localparam logic [CMD_W-1:0]      RST_CODE_B   = 6'd1;
    localparam logic [CMD_W-1:0]      RST_CODE_C   = 6'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_INTERVAL = 2'd0,
        CFG_CODE_A          = 2'd1,
        CFG_CODE_B          = 2'd2,
        CFG_CODE_C          = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] word;
    } t_frame_evt;

    typedef struct packed {
        logic              frame_done;
        logic [CMD_W-1:0]  cmd_code;
        logic [ADDR_W-1:0] device_addr;
        logic              toggle_bit;
        logic              is_repeat;
        logic              out_a;
        logic              out_b;
        logic              out_c;
    } t_result;

endpackage

@@ src/rc5rx_frame.sv @@
module rc5rx_frame
    import rc5rx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_level,
    input  logic [INTERVAL_W-1:0] i_sample_interval,
    output t_frame_evt            o_evt
);

    logic                  r_busy, n_busy;
    logic                  r_prev, n_prev;
    logic [INTERVAL_W-1:0] r_tick, n_tick;
    logic [3:0]            r_sample_cnt, n_sample_cnt;
    logic [WORD_W-1:0]     r_shift, n_shift;
    logic [INTERVAL_W:0]   tick_inc;
    logic                  hit;

    assign tick_inc = {1'b0, r_tick} + {{INTERVAL_W{1'b0}}, 1'b1};
    assign hit      = tick_inc[INTERVAL_W] || (tick_inc[INTERVAL_W-1:0] >= i_sample_interval);

    always_comb begin
        n_busy       = r_busy;
        n_prev       = r_prev;
        n_tick       = r_tick;
        n_sample_cnt = r_sample_cnt;
        n_shift      = r_shift;
        o_evt.done   = 1'b0;
        o_evt.word   = r_shift;
        if (i_step) begin
            n_prev = i_level;
            if (!r_busy) begin
                if (r_prev && !i_level) begin
                    n_busy       = 1'b1;
                    n_shift      = {{(WORD_W-1){1'b0}}, 1'b1};
                    n_tick       = '0;
                    n_sample_cnt = '0;
                end
            end else if (hit) begin
                n_tick = '0;
                if (r_sample_cnt >= LAST_SAMPLE) begin
                    o_evt.done   = 1'b1;
                    n_busy       = 1'b0;
                    n_sample_cnt = '0;
                end else begin
                    n_shift      = {r_shift[WORD_W-2:0], ~i_level};
                    n_sample_cnt = r_sample_cnt + 4'd1;
                end
            end else begin
                n_tick = tick_inc[INTERVAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_prev       <= 1'b1;
            r_tick       <= '0;
            r_sample_cnt <= '0;
            r_shift      <= '0;
        end else begin
            r_busy       <= n_busy;
            r_prev       <= n_prev;
            r_tick       <= n_tick;
            r_sample_cnt <= n_sample_cnt;
            r_shift      <= n_shift;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sample_cnt <= LAST_SAMPLE)
        else $error("sample count beyond frame length");

    a_idle_count_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_sample_cnt == '0)
        else $error("sample count not cleared while idle");

    a_done_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.done |-> r_busy && i_step)
        else $error("frame end outside a frame");

endmodule

@@ src/rc5rx_decode.sv @@
module rc5rx_decode
    import rc5rx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_frame_evt       i_evt,
    input  logic [CMD_W-1:0] i_code_a,
    input  logic [CMD_W-1:0] i_code_b,
    input  logic [CMD_W-1:0] i_code_c,
    output t_result          o_result
);

    logic [CMD_W-1:0]  r_last_cmd, n_last_cmd;
    logic              r_last_tog, n_last_tog;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_tog, n_tog;
    logic              r_rep, n_rep;
    logic [2:0]        r_levels, n_levels;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic              tog;
    logic              rep;
    logic              decode;

    assign cmd    = i_evt.word[CMD_W-1:0];
    assign addr   = i_evt.word[CMD_W+ADDR_W-1:CMD_W];
    assign tog    = i_evt.word[WORD_W-1];
    assign rep    = (cmd == r_last_cmd) && (tog == r_last_tog);
    assign decode = i_step && i_evt.done;

    always_comb begin
        n_last_cmd = r_last_cmd;
        n_last_tog = r_last_tog;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_tog      = r_tog;
        n_rep      = r_rep;
        n_levels   = r_levels;
        if (decode) begin
            n_cmd  = cmd;
            n_addr = addr;
            n_tog  = tog;
            n_rep  = rep;
            if (!rep) begin
                n_last_cmd = cmd;
                n_last_tog = tog;
                n_levels   = r_levels ^ {cmd == i_code_c, cmd == i_code_b, cmd == i_code_a};
            end
        end
    end

    always_comb begin
        o_result.frame_done  = decode;
        o_result.cmd_code    = n_cmd;
        o_result.device_addr = n_addr;
        o_result.toggle_bit  = n_tog;
        o_result.is_repeat   = n_rep;
        o_result.out_a       = n_levels[0];
        o_result.out_b       = n_levels[1];
        o_result.out_c       = n_levels[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd <= '0;
            r_last_tog <= 1'b0;
            r_cmd      <= '0;
            r_addr     <= '0;
            r_tog      <= 1'b0;
            r_rep      <= 1'b0;
            r_levels   <= 3'b011;
        end else begin
            r_last_cmd <= n_last_cmd;
            r_last_tog <= n_last_tog;
            r_cmd      <= n_cmd;
            r_addr     <= n_addr;
            r_tog      <= n_tog;
            r_rep      <= n_rep;
            r_levels   <= n_levels;
        end
    end

    a_fields_match_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd == r_last_cmd && r_tog == r_last_tog)
        else $error("decoded fields disagree with stored command");

    a_levels_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !decode |=> $stable(r_levels))
        else $error("output levels changed without a decoded frame");

endmodule

@@ src/rc5_ir_frame_receiver_top.sv @@
// RC5 infrared frame receiver. Each input transfer is one tick of the sampling
// clock carrying the raw active-low receiver level, and each one yields exactly one
// result transfer, in order. The block takes one transfer per cycle unless an unread
// result stalls it; each transfer is held in the input register, then updates the
// frame state and loads the result register. A falling edge while idle starts a
// frame, the line is sampled every sample_interval ticks, and after thirteen samples the
// next interval decodes command, address and toggle, marks repeats, and if not a repeat
// flips levels whose configured codes match. Configuration writes are meant for idle time.
module rc5_ir_frame_receiver_top
    import rc5rx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_ir_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_frame_done,
    output logic [CMD_W-1:0]      o_cmd_code,
    output logic [ADDR_W-1:0]     o_device_addr,
    output logic                  o_toggle_bit,
    output logic                  o_is_repeat,
    output logic                  o_out_a,
    output logic                  o_out_b,
    output logic                  o_out_c
);

    logic [INTERVAL_W-1:0] r_interval;
    logic [CMD_W-1:0]      r_code_a, r_code_b, r_code_c;
    logic                  r_in_valid;
    logic                  r_in_level;
    logic                  r_out_valid;
    t_result               r_out;
    t_result               n_result;
    t_frame_evt            evt;
    logic                  step;

    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= RST_INTERVAL;
            r_code_a   <= RST_CODE_A;
            r_code_b   <= RST_CODE_B;
            r_code_c   <= RST_CODE_C;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLE_INTERVAL: r_interval <= i_cfg_data[INTERVAL_W-1:0];
                CFG_CODE_A:          r_code_a   <= i_cfg_data[CMD_W-1:0];
                CFG_CODE_B:          r_code_b   <= i_cfg_data[CMD_W-1:0];
                CFG_CODE_C:          r_code_c   <= i_cfg_data[CMD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_level <= i_ir_level;
        end
    end

    rc5rx_frame u_frame (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_level           (r_in_level),
        .i_sample_interval (r_interval),
        .o_evt             (evt)
    );

    rc5rx_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_evt    (evt),
        .i_code_a (r_code_a),
        .i_code_b (r_code_b),
        .i_code_c (r_code_c),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame_done  = r_out.frame_done;
    assign o_cmd_code    = r_out.cmd_code;
    assign o_device_addr = r_out.device_addr;
    assign o_toggle_bit  = r_out.toggle_bit;
    assign o_is_repeat   = r_out.is_repeat;
    assign o_out_a       = r_out.out_a;
    assign o_out_b       = r_out.out_b;
    assign o_out_c       = r_out.out_c;

endmodule

@@ test/rc5_ir_frame_receiver_top_tb.sv @@
`timescale 1ns / 1ps

module rc5_ir_frame_receiver_top_tb;
    import rc5rx_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 300;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_ir_level;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic                  o_frame_done;
    logic [CMD_W-1:0]      o_cmd_code;
    logic [ADDR_W-1:0]     o_device_addr;
    logic                  o_toggle_bit;
    logic                  o_is_repeat;
    logic                  o_out_a;
    logic                  o_out_b;
    logic                  o_out_c;

    // Receiver state mirrored on the bench side.
    logic [INTERVAL_W-1:0] rx_interval;
    logic [CMD_W-1:0]      rx_code_a;
    logic [CMD_W-1:0]      rx_code_b;
    logic [CMD_W-1:0]      rx_code_c;
    logic                  rx_busy;
    logic                  rx_prev_level;
    logic [15:0]           rx_tick_cnt;
    logic [3:0]            rx_sample_cnt;
    logic [13:0]           rx_shift;
    logic [CMD_W-1:0]      rx_last_cmd;
    logic                  rx_last_tog;
    logic [CMD_W-1:0]      rx_cmd;
    logic [ADDR_W-1:0]     rx_addr;
    logic                  rx_tog;
    logic                  rx_rep;
    logic [2:0]            rx_levels;

    t_result rx_outputs_due[$];
    t_result got;
    t_result want;

    int  mismatches = 0;
    int  cycles = 0;
    int  sent_count = 0;
    int  stall_left = 0;
    bit  idle_on = 1'b1;

    rc5_ir_frame_receiver_top u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ir_level   (i_ir_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_done (o_frame_done),
        .o_cmd_code   (o_cmd_code),
        .o_device_addr(o_device_addr),
        .o_toggle_bit (o_toggle_bit),
        .o_is_repeat  (o_is_repeat),
        .o_out_a      (o_out_a),
        .o_out_b      (o_out_b),
        .o_out_c      (o_out_c)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // One tick of the line: advances the frame state and queues the outputs it yields.
    task automatic rc5_advance(input logic lvl);
        t_result due;
        due.frame_done = 1'b0;
        if (!rx_busy) begin
            if (rx_prev_level && !lvl) begin
                rx_busy       = 1'b1;
                rx_shift      = 14'd1;
                rx_tick_cnt   = '0;
                rx_sample_cnt = '0;
            end
        end else begin
            rx_tick_cnt = rx_tick_cnt + 16'd1;
            if (rx_tick_cnt == 16'd0 || rx_tick_cnt >= rx_interval) begin
                rx_tick_cnt = '0;
                if (rx_sample_cnt >= LAST_SAMPLE) begin
                    rx_cmd  = rx_shift[5:0];
                    rx_addr = rx_shift[10:6];
                    rx_tog  = rx_shift[11];
                    rx_rep  = (rx_cmd == rx_last_cmd) && (rx_tog == rx_last_tog);
                    if (!rx_rep) begin
                        rx_last_cmd = rx_cmd;
                        rx_last_tog = rx_tog;
                        if (rx_cmd == rx_code_a) rx_levels[0] = ~rx_levels[0];
                        if (rx_cmd == rx_code_b) rx_levels[1] = ~rx_levels[1];
                        if (rx_cmd == rx_code_c) rx_levels[2] = ~rx_levels[2];
                    end
                    rx_busy        = 1'b0;
                    rx_sample_cnt  = '0;
                    due.frame_done = 1'b1;
                end else begin
                    rx_shift      = {rx_shift[12:0], ~lvl};
                    rx_sample_cnt = rx_sample_cnt + 4'd1;
                end
            end
        end
        rx_prev_level   = lvl;
        due.cmd_code    = rx_cmd;
        due.device_addr = rx_addr;
        due.toggle_bit  = rx_tog;
        due.is_repeat   = rx_rep;
        due.out_a       = rx_levels[0];
        due.out_b       = rx_levels[1];
        due.out_c       = rx_levels[2];
        rx_outputs_due.push_back(due);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_level(input logic lvl);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ir_level <= lvl;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rc5_advance(lvl);
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (rx_outputs_due.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SAMPLE_INTERVAL: rx_interval = value;
            CFG_CODE_A:          rx_code_a   = value[CMD_W-1:0];
            CFG_CODE_B:          rx_code_b   = value[CMD_W-1:0];
            CFG_CODE_C:          rx_code_c   = value[CMD_W-1:0];
        endcase
    endtask

    task automatic send_start_edge;
        send_level(1'b1);
        send_level(1'b0);
    endtask

    // Sends the thirteen sampled bits (field, toggle, address, command) and the
    // decode interval. Between samples the line holds or carries noise.
    task automatic send_rc5_bits(input logic [12:0] bits, input int first_wait,
                                 input int ival, input bit noisy, input logic end_level);
        int k;
        int j;
        int gap;
        for (k = 12; k >= 0; k--) begin
            gap = (k == 12) ? first_wait : ival;
            for (j = 1; j < gap; j++) begin
                send_level(noisy ? 1'($urandom_range(0, 1)) : ~bits[k]);
            end
            send_level(~bits[k]);
        end
        for (j = 1; j < ival; j++) begin
            send_level(noisy ? 1'($urandom_range(0, 1)) : end_level);
        end
        send_level(end_level);
    endtask

    task automatic test_first_frame_is_repeat;
        write_reg(CFG_SAMPLE_INTERVAL, 16'd1);
        send_start_edge();
        send_rc5_bits({1'b1, 1'b0, 5'd31, 6'd0}, 1, 1, 1'b0, 1'b1);
    endtask

    task automatic test_zero_interval;
        write_reg(CFG_SAMPLE_INTERVAL, 16'd0);
        send_start_edge();
        send_rc5_bits({1'b0, 1'b1, 5'd21, 6'd7}, 1, 1, 1'b0, 1'b1);
    endtask

    task automatic test_equal_codes;
        write_reg(CFG_CODE_A, 16'd63);
        write_reg(CFG_CODE_B, 16'd63);
        write_reg(CFG_CODE_C, 16'd63);
        send_start_edge();
        send_rc5_bits({1'b1, 1'b0, 5'd0, 6'd63}, 1, 1, 1'b0, 1'b1);
    endtask

    task automatic test_no_start_on_decode_tick;
        send_start_edge();
        send_rc5_bits({1'b1, 1'b1, 5'd10, 6'd42}, 1, 1, 1'b0, 1'b0);
        send_level(1'b0);
        send_level(1'b1);
    endtask

    task automatic test_interval_lowered_mid_frame;
        write_reg(CFG_SAMPLE_INTERVAL, 16'hFFFF);
        send_start_edge();
        repeat (3) send_level(1'b1);
        write_reg(CFG_SAMPLE_INTERVAL, 16'd2);
        send_rc5_bits({1'b1, 1'b0, 5'd5, 6'd1}, 1, 2, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic;
        int stop_at;
        int raw;
        int ival;
        int pick;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic              tog;
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at) begin
            idle_on = (sent_count > stop_at - 80) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) raw = 0;
            else if (pick == 1) raw = $urandom_range(4, 6);
            else raw = $urandom_range(1, 3);
            ival = (raw == 0) ? 1 : raw;
            write_reg(CFG_SAMPLE_INTERVAL, 16'(raw));
            if ($urandom_range(0, 2) == 0) begin
                write_reg(t_cfg_idx'($urandom_range(1, 3)), 16'($urandom_range(0, 63)));
            end
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 12)) send_level(1'($urandom_range(0, 1)));
                end else begin
                    pick = $urandom_range(0, 9);
                    tog  = 1'($urandom_range(0, 1));
                    addr = 5'($urandom);
                    if (pick < 2) cmd = rx_code_a;
                    else if (pick == 2) cmd = rx_code_b;
                    else if (pick == 3) cmd = rx_code_c;
                    else if (pick < 6) begin
                        cmd = rx_last_cmd;
                        tog = rx_last_tog;
                    end else cmd = 6'($urandom);
                    repeat ($urandom_range(0, 2)) send_level(1'b1);
                    send_start_edge();
                    send_rc5_bits({1'($urandom_range(0, 1)), tog, addr, cmd}, ival, ival,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_frame_done, o_cmd_code, o_device_addr, o_toggle_bit, o_is_repeat,
                   o_out_a, o_out_b, o_out_c};
            if (rx_outputs_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: done=%0d cmd=%0d addr=%0d",
                             got.frame_done, got.cmd_code, got.device_addr);
                end
            end else begin
                want = rx_outputs_due.pop_front();
                if (got.frame_done !== want.frame_done || got.cmd_code !== want.cmd_code ||
                    got.device_addr !== want.device_addr ||
                    got.toggle_bit !== want.toggle_bit || got.is_repeat !== want.is_repeat ||
                    got.out_a !== want.out_a || got.out_b !== want.out_b ||
                    got.out_c !== want.out_c) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch at %0t: expected done=%0d cmd=%0d addr=%0d",
                                  " tog=%0d rep=%0d abc=%0d%0d%0d"},
                                 $realtime, want.frame_done, want.cmd_code, want.device_addr,
                                 want.toggle_bit, want.is_repeat, want.out_a, want.out_b,
                                 want.out_c);
                        $display({"    actual   done=%0d cmd=%0d addr=%0d",
                                  " tog=%0d rep=%0d abc=%0d%0d%0d"},
                                 got.frame_done, got.cmd_code, got.device_addr,
                                 got.toggle_bit, got.is_repeat, got.out_a, got.out_b,
                                 got.out_c);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_SAMPLE_INTERVAL;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_ir_level  = 1'b1;
        i_out_ready = 1'b0;

        rx_interval   = RST_INTERVAL;
        rx_code_a     = RST_CODE_A;
        rx_code_b     = RST_CODE_B;
        rx_code_c     = RST_CODE_C;
        rx_busy       = 1'b0;
        rx_prev_level = 1'b1;
        rx_tick_cnt   = '0;
        rx_sample_cnt = '0;
        rx_shift      = '0;
        rx_last_cmd   = '0;
        rx_last_tog   = 1'b0;
        rx_cmd        = '0;
        rx_addr       = '0;
        rx_tog        = 1'b0;
        rx_rep        = 1'b0;
        rx_levels     = 3'b011;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_frame_is_repeat();
        test_zero_interval();
        test_equal_codes();
        test_no_start_on_decode_tick();
        test_interval_lowered_mid_frame();
        test_random_traffic();

        wait_drained();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && rx_outputs_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/rc5rx_pkg.sv
src/rc5rx_frame.sv
src/rc5rx_decode.sv
src/rc5_ir_frame_receiver_top.sv
test/rc5_ir_frame_receiver_top_tb.sv
